FILE: rtl/core/dptp_pkg.sv
// Package for the decimal pair text parser: payload structs, character codes
// and fixed widths of the accumulators. No dependencies.
`default_nettype none

package dptp_pkg;

   // Width of one signed fixed-point result and of each magnitude register.
   localparam int unsigned ACC_WIDTH = 48;
   // Working width of a digit step: ten times the largest magnitude fits.
   localparam int unsigned SUM_WIDTH = ACC_WIDTH + 4;

   localparam logic [ACC_WIDTH-1:0] MAX_MAG = {1'b0, {(ACC_WIDTH-1){1'b1}}};

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_line;
   } req_type;

   typedef struct packed {
      logic signed [ACC_WIDTH-1:0] x_value;
      logic signed [ACC_WIDTH-1:0] y_value;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/core/decimal_pair_text_parser_top.sv
// Decimal pair text parser top level; depends on dptp_pkg.
// Characters are parsed from the input register; end of line loads the result register.
// Throughput: one character per cycle unless an end-of-line character waits on
// an untaken result, set by the combinational digit update (shift-add by ten
// or one small table multiply) on the accumulator loop.
// Synchronous active-high reset empties both stages and clears parser state.
`default_nettype none

module decimal_pair_text_parser_top
   import dptp_pkg::*;
#(
   parameter int unsigned FRAC_BITS       = 16,
   parameter int unsigned MAX_FRAC_DIGITS = 6
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   // Place-value table: entry k holds round(2^FRAC_BITS / 10^k), halves up.
   localparam longint unsigned ONE_FIX = 64'd1 << FRAC_BITS;
   localparam int unsigned PW = FRAC_BITS + 1;
   localparam logic [PW-1:0] PLACE_VALUE [8] = '{
      PW'(ONE_FIX),
      PW'((ONE_FIX + 64'd5) / 64'd10),
      PW'((ONE_FIX + 64'd50) / 64'd100),
      PW'((ONE_FIX + 64'd500) / 64'd1000),
      PW'((ONE_FIX + 64'd5000) / 64'd10000),
      PW'((ONE_FIX + 64'd50000) / 64'd100000),
      PW'((ONE_FIX + 64'd500000) / 64'd1000000),
      PW'((ONE_FIX + 64'd5000000) / 64'd10000000)
   };
   localparam logic [2:0] FRAC_LIMIT = 3'(MAX_FRAC_DIGITS);

   // Input register stage. One transaction is held here until it is parsed.
   logic       in_valid_ff, in_valid_in;
   req_type    in_data_ff;

   // Parser state.
   logic [ACC_WIDTH-1:0] first_accum_ff, first_accum_in;
   logic [ACC_WIDTH-1:0] second_accum_ff, second_accum_in;
   logic                 in_second_ff, in_second_in;
   logic                 sign_pending_ff, sign_pending_in;
   logic                 after_point_ff, after_point_in;
   logic [2:0]           frac_digits_ff, frac_digits_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // The held character is parsed unless it ends a line while the result
   // register is still occupied by a result the consumer has not taken.
   logic parse_fire;
   assign parse_fire = in_valid_ff &&
                       !(in_data_ff.end_of_line && rsp_valid_ff && !rsp_ready);

   assign req_ready = !in_valid_ff || parse_fire;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (parse_fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Character classification.
   logic       is_digit, is_space, is_point, is_minus;
   logic [3:0] digit;

   assign is_digit = in_data_ff.char_code inside {[CHAR_ZERO:CHAR_NINE]};
   assign is_space = in_data_ff.char_code == CHAR_SPACE;
   assign is_point = in_data_ff.char_code inside {CHAR_DOT, CHAR_COMMA};
   assign is_minus = in_data_ff.char_code == CHAR_MINUS;
   assign digit    = 4'(in_data_ff.char_code - CHAR_ZERO);

   // Digit step on the accumulator of the current field.
   logic [ACC_WIDTH-1:0] active_acc, digit_acc;
   logic [SUM_WIDTH-1:0] acc_ext, int_sum, frac_sum, step_sum;
   logic [2:0]           frac_count_next;
   logic [PW-1:0]        place_sel;
   logic [PW+3:0]        frac_prod;
   logic                 frac_full;

   assign active_acc      = in_second_ff ? second_accum_ff : first_accum_ff;
   assign acc_ext         = SUM_WIDTH'(active_acc);
   assign frac_count_next = frac_digits_ff + 3'd1;
   assign place_sel       = PLACE_VALUE[frac_count_next];
   assign frac_prod       = (PW+4)'(digit) * (PW+4)'(place_sel);
   assign frac_full       = frac_digits_ff >= FRAC_LIMIT;

   // Times ten is a shift by three plus a shift by one.
   assign int_sum  = (acc_ext << 3) + (acc_ext << 1) + (SUM_WIDTH'(digit) << FRAC_BITS);
   assign frac_sum = acc_ext + SUM_WIDTH'(frac_prod);
   assign step_sum = after_point_ff ? frac_sum : int_sum;

   always_comb begin
      if (after_point_ff && frac_full) begin
         digit_acc = active_acc;
      end else if (step_sum > SUM_WIDTH'(MAX_MAG)) begin
         digit_acc = MAX_MAG;
      end else begin
         digit_acc = step_sum[ACC_WIDTH-1:0];
      end
   end

   // Next parser state for the held character, before the end-of-line clear.
   logic [ACC_WIDTH-1:0] first_next, second_next;
   logic                 in_second_next, sign_next, point_next;
   logic [2:0]           frac_next;

   always_comb begin
      first_next     = first_accum_ff;
      second_next    = second_accum_ff;
      in_second_next = in_second_ff;
      sign_next      = sign_pending_ff;
      point_next     = after_point_ff;
      frac_next      = frac_digits_ff;
      if (is_space) begin
         // Only the first space separates the fields; later ones are ignored.
         if (!in_second_ff) begin
            in_second_next = 1'b1;
            point_next     = 1'b0;
            frac_next      = 3'd0;
            if (sign_pending_ff) begin
               sign_next  = 1'b0;
               first_next = ACC_WIDTH'(0) - first_accum_ff;
            end
         end
      end else if (is_point) begin
         point_next = 1'b1;
      end else if (is_minus) begin
         sign_next = 1'b1;
      end else if (is_digit) begin
         if (after_point_ff && !frac_full) begin
            frac_next = frac_count_next;
         end
         if (in_second_ff) begin
            second_next = digit_acc;
         end else begin
            first_next = digit_acc;
         end
      end
   end

   // State update. The last character of a line clears everything.
   always_comb begin
      first_accum_in  = first_accum_ff;
      second_accum_in = second_accum_ff;
      in_second_in    = in_second_ff;
      sign_pending_in = sign_pending_ff;
      after_point_in  = after_point_ff;
      frac_digits_in  = frac_digits_ff;
      if (parse_fire) begin
         if (in_data_ff.end_of_line) begin
            first_accum_in  = '0;
            second_accum_in = '0;
            in_second_in    = 1'b0;
            sign_pending_in = 1'b0;
            after_point_in  = 1'b0;
            frac_digits_in  = 3'd0;
         end else begin
            first_accum_in  = first_next;
            second_accum_in = second_next;
            in_second_in    = in_second_next;
            sign_pending_in = sign_next;
            after_point_in  = point_next;
            frac_digits_in  = frac_next;
         end
      end
   end

   // Result register. A sign still pending at end of line negates the second
   // number, even when the line had no separating space.
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (parse_fire && in_data_ff.end_of_line) begin
         rsp_valid_in        = 1'b1;
         rsp_data_in.x_value = first_next;
         rsp_data_in.y_value = sign_next ? ACC_WIDTH'(0) - second_next : second_next;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         first_accum_ff  <= '0;
         second_accum_ff <= '0;
         in_second_ff    <= 1'b0;
         sign_pending_ff <= 1'b0;
         after_point_ff  <= 1'b0;
         frac_digits_ff  <= 3'd0;
      end else begin
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         first_accum_ff  <= first_accum_in;
         second_accum_ff <= second_accum_in;
         in_second_ff    <= in_second_in;
         sign_pending_ff <= sign_pending_in;
         after_point_ff  <= after_point_in;
         frac_digits_ff  <= frac_digits_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // A parsed end-of-line transaction always lands in the result register.
   assert property (@(posedge clock) disable iff (reset)
      parse_fire && in_data_ff.end_of_line |=> rsp_valid_ff)
      else $error("end-of-line transaction produced no result");

   // All parser state is clear after the last character of a line.
   assert property (@(posedge clock) disable iff (reset)
      parse_fire && in_data_ff.end_of_line |=>
         first_accum_ff == '0 && second_accum_ff == '0 && !in_second_ff &&
         !sign_pending_ff && !after_point_ff && frac_digits_ff == 3'd0)
      else $error("parser state not cleared at end of line");

   // The fractional digit count never passes its limit.
   assert property (@(posedge clock) disable iff (reset)
      frac_digits_ff <= FRAC_LIMIT)
      else $error("fractional digit count beyond limit");

   // The second magnitude never exceeds the largest positive value.
   assert property (@(posedge clock) disable iff (reset)
      second_accum_ff <= MAX_MAG)
      else $error("second magnitude beyond saturation bound");
`endif

endmodule

`default_nettype wire
